### rtl/dvrt_pkg.sv
// Shared types and constants of the distance-vector route table.
// Field widths, operation and result codes, item structs, controller states.
// No dependencies; compile first.
package dvrt_pkg;

   localparam int OP_W   = 3;
   localparam int NODE_W = 5;
   localparam int DIST_W = 8;
   localparam int PORT_W = 3;
   localparam int KIND_W = 4;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ADVERTISE = 3'd0,
      OP_FAILED    = 3'd1,
      OP_LINK_DOWN = 3'd2,
      OP_LOGGER    = 3'd3,
      OP_LOOKUP    = 3'd4
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FWD_ROUTE    = 4'd0,
      KIND_REPLY_ROUTE  = 4'd1,
      KIND_FWD_FAILED   = 4'd2,
      KIND_NODE_LOST    = 4'd3,
      KIND_LINKDOWN_DONE = 4'd4,
      KIND_FWD_LOGGER   = 4'd5,
      KIND_REPLY_LOGGER = 4'd6,
      KIND_LOCAL        = 4'd7,
      KIND_FOUND        = 4'd8,
      KIND_NO_PATH      = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] node_id;
      logic [DIST_W-1:0] distance;
      logic [PORT_W-1:0] port;
   } req_item_type;

   typedef struct packed {
      kind_type          kind;
      logic [NODE_W-1:0] node_id_res;
      logic [DIST_W-1:0] distance_res;
      logic [PORT_W-1:0] port_res;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [PORT_W-1:0] port;
   } entry_type;

   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] d);
      return (d == DIST_MAX) ? d : d + DIST_W'(1);
   endfunction

endpackage

### rtl/dvrt_if.sv
// Valid/ready channel interfaces for route events and route results.
// Depends on dvrt_pkg for field widths.
interface dvrt_req_if import dvrt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [NODE_W-1:0] node_id;
   logic [DIST_W-1:0] distance;
   logic [PORT_W-1:0] port;

   modport source (output valid, op, node_id, distance, port, input ready);
   modport sink   (input valid, op, node_id, distance, port, output ready);
endinterface

interface dvrt_rsp_if import dvrt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [NODE_W-1:0] node_id_res;
   logic [DIST_W-1:0] distance_res;
   logic [PORT_W-1:0] port_res;
   logic              last;

   modport source (output valid, kind, node_id_res, distance_res, port_res, last,
                   input ready);
   modport sink   (input valid, kind, node_id_res, distance_res, port_res, last,
                   output ready);
endinterface

### rtl/dvrt_route_mem.sv
// Route entry memory: distance and port per node id, one write and one
// registered read port. Depends on dvrt_pkg for entry_type.
module dvrt_route_mem import dvrt_pkg::*; #(
   parameter int  DEPTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dvrt_engine.sv
// Route table controller: valid bits, logger entry, per-item evaluation and
// the link-down table scan. Depends on dvrt_pkg; drives dvrt_route_mem ports.
module dvrt_engine import dvrt_pkg::*; #(
   parameter int  NODE_COUNT = 32,
   parameter int  PORT_COUNT = 8,
   localparam int IDX_W      = $clog2(NODE_COUNT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_item_type      item,
   input  logic [NODE_W-1:0] own_node,
   input  logic              out_free,
   output logic              ready,
   output logic              emit,
   output rsp_item_type      emit_item,
   output logic              mem_rd_en,
   output logic [IDX_W-1:0]  mem_rd_addr,
   input  entry_type         mem_rd_data,
   output logic              mem_wr_en,
   output logic [IDX_W-1:0]  mem_wr_addr,
   output entry_type         mem_wr_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

   state_type         state_ff, state_in;
   req_item_type      item_ff, item_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [NODE_COUNT-1:0] valid_ff, valid_in;
   logic              logger_valid_ff, logger_valid_in;
   logic [NODE_W-1:0] logger_node_ff, logger_node_in;
   logic [DIST_W-1:0] logger_dist_ff, logger_dist_in;

   logic [IDX_W-1:0]  node_idx;
   logic [DIST_W-1:0] d1;
   logic              node_ok, port_ok, range_ok, own_hit, entry_valid, scan_hit;

   logic              ev_has_res, ev_wr_route, ev_clr_valid;
   logic              ev_set_logger, ev_clr_logger, ev_scan;
   rsp_item_type      ev_res;

   assign node_idx    = IDX_W'(item_ff.node_id);
   assign d1          = sat_inc(item_ff.distance);
   assign node_ok     = int'(item_ff.node_id) < NODE_COUNT;
   assign port_ok     = int'(item_ff.port) < PORT_COUNT;
   assign range_ok    = node_ok && port_ok;
   assign own_hit     = (item_ff.node_id == own_node);
   assign entry_valid = node_ok && valid_ff[node_idx];
   assign scan_hit    = valid_ff[scan_idx_ff] && (mem_rd_data.port == item_ff.port);

   // Decide the outcome of one event from the registered entry read issued when it was taken
   always_comb begin
      ev_has_res          = 1'b0;
      ev_wr_route         = 1'b0;
      ev_clr_valid        = 1'b0;
      ev_set_logger       = 1'b0;
      ev_clr_logger       = 1'b0;
      ev_scan             = 1'b0;
      ev_res.kind         = KIND_FWD_ROUTE;
      ev_res.node_id_res  = item_ff.node_id;
      ev_res.distance_res = '0;
      ev_res.port_res     = item_ff.port;
      ev_res.last         = 1'b1;
      unique case (item_ff.op)
         OP_ADVERTISE: begin
            if (range_ok && !own_hit) begin
               if (!entry_valid || mem_rd_data.distance > d1) begin
                  ev_wr_route         = 1'b1;
                  ev_has_res          = 1'b1;
                  ev_res.distance_res = d1;
               end else if (sat_inc(mem_rd_data.distance) < item_ff.distance) begin
                  ev_has_res          = 1'b1;
                  ev_res.kind         = KIND_REPLY_ROUTE;
                  ev_res.distance_res = mem_rd_data.distance;
               end
            end
         end
         OP_FAILED: begin
            if (range_ok && entry_valid) begin
               ev_has_res = 1'b1;
               if (mem_rd_data.port == item_ff.port) begin
                  ev_clr_valid  = 1'b1;
                  ev_clr_logger = logger_valid_ff && (logger_node_ff == item_ff.node_id);
                  ev_res.kind   = KIND_FWD_FAILED;
               end else begin
                  ev_res.kind         = KIND_REPLY_ROUTE;
                  ev_res.distance_res = mem_rd_data.distance;
               end
            end
         end
         OP_LINK_DOWN: begin
            ev_scan = range_ok;
         end
         OP_LOGGER: begin
            if (range_ok) begin
               if (!logger_valid_ff || logger_dist_ff > d1) begin
                  ev_set_logger       = 1'b1;
                  ev_has_res          = 1'b1;
                  ev_res.kind         = KIND_FWD_LOGGER;
                  ev_res.distance_res = d1;
               end else if (logger_dist_ff < d1) begin
                  ev_has_res          = 1'b1;
                  ev_res.kind         = KIND_REPLY_LOGGER;
                  ev_res.node_id_res  = logger_node_ff;
                  ev_res.distance_res = logger_dist_ff;
               end
            end
         end
         OP_LOOKUP: begin
            ev_has_res = 1'b1;
            if (own_hit) begin
               ev_res.kind     = KIND_LOCAL;
               ev_res.port_res = '0;
            end else if (entry_valid) begin
               ev_res.kind         = KIND_FOUND;
               ev_res.distance_res = mem_rd_data.distance;
               ev_res.port_res     = mem_rd_data.port;
            end else begin
               ev_res.kind     = KIND_NO_PATH;
               ev_res.port_res = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         valid_ff        <= '0;
         logger_valid_ff <= 1'b0;
         logger_node_ff  <= '0;
         logger_dist_ff  <= '0;
      end else begin
         state_ff        <= state_in;
         valid_ff        <= valid_in;
         logger_valid_ff <= logger_valid_in;
         logger_node_ff  <= logger_node_in;
         logger_dist_ff  <= logger_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      scan_idx_ff <= scan_idx_in;
   end

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      scan_idx_in     = scan_idx_ff;
      valid_in        = valid_ff;
      logger_valid_in = logger_valid_ff;
      logger_node_in  = logger_node_ff;
      logger_dist_in  = logger_dist_ff;
      ready           = 1'b0;
      emit            = 1'b0;
      emit_item       = ev_res;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = IDX_W'(item.node_id);
      mem_wr_en       = 1'b0;
      mem_wr_addr     = node_idx;
      mem_wr_data     = '{distance: d1, port: item_ff.port};
      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               item_in   = item;
               mem_rd_en = 1'b1;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // hold until the output register can take the result
            if (!ev_has_res || out_free) begin
               emit = ev_has_res;
               if (ev_wr_route) begin
                  mem_wr_en          = 1'b1;
                  valid_in[node_idx] = 1'b1;
               end
               if (ev_clr_valid) begin
                  valid_in[node_idx] = 1'b0;
               end
               if (ev_set_logger) begin
                  logger_valid_in = 1'b1;
                  logger_node_in  = item_ff.node_id;
                  logger_dist_in  = d1;
               end else if (ev_clr_logger) begin
                  logger_valid_in = 1'b0;
                  logger_node_in  = '0;
                  logger_dist_in  = '0;
               end
               scan_idx_in = '0;
               state_in    = ev_scan ? ST_SCAN_RD : ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = scan_idx_ff;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            emit_item.kind         = KIND_NODE_LOST;
            emit_item.node_id_res  = NODE_W'(scan_idx_ff);
            emit_item.distance_res = '0;
            emit_item.port_res     = item_ff.port;
            emit_item.last         = 1'b0;
            if (!scan_hit || out_free) begin
               emit = scan_hit;
               if (scan_hit) begin
                  valid_in[scan_idx_ff] = 1'b0;
               end
               if (scan_idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
                  state_in    = ST_SCAN_RD;
               end
            end
         end
         ST_DONE: begin
            emit_item.kind         = KIND_LINKDOWN_DONE;
            emit_item.node_id_res  = '0;
            emit_item.distance_res = '0;
            emit_item.port_res     = item_ff.port;
            emit_item.last         = 1'b1;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/distance_vector_route_table.sv
// Distance-vector route table, one entry per node id.
// Depends on dvrt_pkg, dvrt_if, dvrt_route_mem and dvrt_engine.
//
// req_chan carries routing events (advertise, failed node, link down, logger
// advert, lookup); a transfer happens when valid and ready are both high.
// rsp_chan returns zero or more results per event, in order; last marks the
// final result of an event. csr_wr_en/csr_wr_data write the own node id;
// the user must write it only while the block is idle; the block does not enforce this.
//
// Each event reads its table entry from a memory with a registered read port
// and updates the table, where the event calls for it, in the evaluate state;
// ready is low from the cycle after a transfer until the event is done, so no
// new event is taken before then; each result goes to the output register.
// A link-down event with an in-range node id and port scans the whole table,
// reading and then checking each entry, with one node lost result per cleared
// route and a closing done result.
// The output register takes a new result while the previous one is being
// transferred; when the receiver stalls, a controller with a result to give holds its state and
// stops taking events until the register frees up.
// Reset clears all route valid bits, the logger entry and the own node id.
module distance_vector_route_table import dvrt_pkg::*; #(
   parameter int NODE_COUNT = 32,
   parameter int PORT_COUNT = 8
) (
   input  logic              clock,
   input  logic              reset,
   dvrt_req_if.sink          req_chan,
   dvrt_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [NODE_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(NODE_COUNT);

   logic [NODE_W-1:0] own_node_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   req_item_type      req_item;
   logic              req_xfer;
   logic              out_free;
   logic              eng_ready;
   logic              eng_emit;
   rsp_item_type      eng_item;
   logic              mem_rd_en, mem_wr_en;
   logic [IDX_W-1:0]  mem_rd_addr, mem_wr_addr;
   entry_type         mem_rd_data, mem_wr_data;

   assign req_item = '{op: req_chan.op, node_id: req_chan.node_id,
                       distance: req_chan.distance, port: req_chan.port};
   assign req_chan.ready = eng_ready;
   assign req_xfer = req_chan.valid && eng_ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff <= '0;
      end else if (csr_wr_en) begin
         own_node_ff <= csr_wr_data;
      end
   end

   dvrt_engine #(
      .NODE_COUNT (NODE_COUNT),
      .PORT_COUNT (PORT_COUNT)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (req_xfer),
      .item        (req_item),
      .own_node    (own_node_ff),
      .out_free    (out_free),
      .ready       (eng_ready),
      .emit        (eng_emit),
      .emit_item   (eng_item),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   dvrt_route_mem #(
      .DEPTH (NODE_COUNT)
   ) u_route_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Output register: load a new result, or drop the one just transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (eng_emit) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = eng_item;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_item_ff.kind;
   assign rsp_chan.node_id_res  = rsp_item_ff.node_id_res;
   assign rsp_chan.distance_res = rsp_item_ff.distance_res;
   assign rsp_chan.port_res     = rsp_item_ff.port_res;
   assign rsp_chan.last         = rsp_item_ff.last;

   // Never overwrite a result that has not been transferred
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      eng_emit |-> out_free)
      else $error("result emitted while output register is occupied");

   // Ready drops once an event is transferred, as the controller is busy with it
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("ready high right after an event transfer");

   // A node lost result is never marked last, since the done result follows it
   a_node_lost_not_last: assert property (@(posedge clock) disable iff (reset)
      (eng_emit && eng_item.kind == KIND_NODE_LOST) |-> !eng_item.last)
      else $error("node lost result marked last");

endmodule
